FILE: hdl/ldf_pkg.sv
`default_nettype none

package ldf_pkg;

	// Ring and packet limits
	localparam int RING_DEPTH = 256;
	localparam int MAX_PACKET = 32;

	localparam int BYTE_W = 8;
	localparam int PTR_W  = $clog2(RING_DEPTH);
	localparam int FILL_W = $clog2(RING_DEPTH + 1);
	localparam int PKT_W  = $clog2(MAX_PACKET + 1);
	localparam int SUM_W  = ((PTR_W > BYTE_W) ? PTR_W : BYTE_W) + 1;
	localparam int CMP_W  = (FILL_W > BYTE_W) ? FILL_W : BYTE_W;

	// Result status codes
	localparam logic [2:0] ST_STORED   = 3'd0;
	localparam logic [2:0] ST_DATA     = 3'd1;
	localparam logic [2:0] ST_NONE     = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_OVERSIZE = 3'd4;

	typedef struct packed {
		logic [2:0]        status;
		logic [BYTE_W-1:0] data_byte;
		logic              last;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [PTR_W-1:0]  waddr;
		logic [BYTE_W-1:0] wdata;
		logic              re;
		logic [PTR_W-1:0]  raddr;
	} ram_req_t;

endpackage

`default_nettype wire

FILE: hdl/ldf_ram.sv
`default_nettype none

module ldf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold read data while not enabled
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/ldf_ctrl.sv
`default_nettype none

module ldf_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic                         cmd,
	input  wire logic [ldf_pkg::BYTE_W-1:0]   rx_byte,
	output logic                              busy,
	input  wire logic                         room,
	output logic                              push,
	output ldf_pkg::res_t                     res,
	output ldf_pkg::ram_req_t                 ram_req,
	input  wire logic [ldf_pkg::BYTE_W-1:0]   ram_rdata
);

	localparam int PTR_W  = ldf_pkg::PTR_W;
	localparam int FILL_W = ldf_pkg::FILL_W;
	localparam int PKT_W  = ldf_pkg::PKT_W;
	localparam int SUM_W  = ldf_pkg::SUM_W;
	localparam int CMP_W  = ldf_pkg::CMP_W;
	localparam int BYTE_W = ldf_pkg::BYTE_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RX   = 3'd1;
	localparam logic [2:0] S_HEAD = 3'd2;
	localparam logic [2:0] S_SIZE = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]        state_q, state_d;
	logic [PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [BYTE_W-1:0] exp_q, exp_d, bop_q, bop_d, byte_q, byte_d;
	logic [PKT_W-1:0]  cnt_q, cnt_d;

	// shared pointer adder with ring wrap
	logic [PTR_W-1:0]  alu_a, alu_y;
	logic [BYTE_W-1:0] alu_b;
	logic [SUM_W-1:0]  alu_sum;

	logic [BYTE_W-1:0] exp_eff, bop_inc, size;
	logic              full;

	assign alu_sum = SUM_W'(alu_a) + SUM_W'(alu_b);
	assign alu_y   = (alu_sum >= SUM_W'(ldf_pkg::RING_DEPTH)) ?
		PTR_W'(alu_sum - SUM_W'(ldf_pkg::RING_DEPTH)) : PTR_W'(alu_sum);

	assign exp_eff = (bop_q == '0) ? byte_q : exp_q;
	assign bop_inc = bop_q + BYTE_W'(1);
	assign full    = (fill_q == FILL_W'(ldf_pkg::RING_DEPTH));
	assign size    = ram_rdata;
	assign busy    = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		wp_d    = wp_q;
		rp_d    = rp_q;
		fill_d  = fill_q;
		exp_d   = exp_q;
		bop_d   = bop_q;
		byte_d  = byte_q;
		cnt_d   = cnt_q;
		push    = 1'b0;
		res     = '0;
		res.last = 1'b1;
		alu_a   = rp_q;
		alu_b   = BYTE_W'(1);
		ram_req.we    = 1'b0;
		ram_req.waddr = wp_q;
		ram_req.wdata = byte_q;
		ram_req.re    = 1'b0;
		ram_req.raddr = rp_q;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					byte_d  = rx_byte;
					state_d = cmd ? S_HEAD : S_RX;
				end
			end
			S_RX: begin
				alu_a = wp_q;
				if (room) begin
					push       = 1'b1;
					res.status = ldf_pkg::ST_STORED;
					exp_d      = exp_eff;
					if (exp_eff != '0) begin
						if (full) begin
							res.status = ldf_pkg::ST_OVERFLOW;
						end else begin
							ram_req.we = 1'b1;
							wp_d       = alu_y;
							fill_d     = fill_q + FILL_W'(1);
						end
						bop_d = (bop_inc == exp_eff) ? '0 : bop_inc;
					end
					state_d = S_IDLE;
				end
			end
			S_HEAD: begin
				if (fill_q == '0) begin
					if (room) begin
						push       = 1'b1;
						res.status = ldf_pkg::ST_NONE;
						state_d    = S_IDLE;
					end
				end else begin
					ram_req.re = 1'b1;
					state_d    = S_SIZE;
				end
			end
			S_SIZE: begin
				if (size == '0) begin
					if (room) begin
						push       = 1'b1;
						res.status = ldf_pkg::ST_OVERSIZE;
						rp_d       = alu_y;
						fill_d     = fill_q - FILL_W'(1);
						state_d    = S_IDLE;
					end
				end else if (CMP_W'(fill_q) < CMP_W'(size)) begin
					if (room) begin
						push       = 1'b1;
						res.status = ldf_pkg::ST_NONE;
						state_d    = S_IDLE;
					end
				end else if (size > BYTE_W'(ldf_pkg::MAX_PACKET)) begin
					alu_b = size;
					if (room) begin
						push       = 1'b1;
						res.status = ldf_pkg::ST_OVERSIZE;
						rp_d       = alu_y;
						fill_d     = fill_q - FILL_W'(size);
						state_d    = S_IDLE;
					end
				end else begin
					// length byte is the first packet byte and is still on rdata
					cnt_d   = PKT_W'(size);
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (room) begin
					push          = 1'b1;
					res.status    = ldf_pkg::ST_DATA;
					res.data_byte = ram_rdata;
					res.last      = (cnt_q == PKT_W'(1));
					rp_d          = alu_y;
					fill_d        = fill_q - FILL_W'(1);
					cnt_d         = cnt_q - PKT_W'(1);
					if (cnt_q == PKT_W'(1)) begin
						state_d = S_IDLE;
					end else begin
						ram_req.re    = 1'b1;
						ram_req.raddr = alu_y;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wp_q    <= '0;
			rp_q    <= '0;
			fill_q  <= '0;
			exp_q   <= '0;
			bop_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			wp_q    <= wp_d;
			rp_q    <= rp_d;
			fill_q  <= fill_d;
			exp_q   <= exp_d;
			bop_q   <= bop_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= byte_d;
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(ldf_pkg::RING_DEPTH))
		else $error("fill count beyond ring depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("result pushed into a full output register");

	a_ram_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_req.we && ram_req.re))
		else $error("ring write and read in the same cycle");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(push && res.last) |=> (state_q == S_IDLE))
		else $error("sequencer not idle after final result");

	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (cnt_q != '0))
		else $error("emitting with no bytes left");

endmodule

`default_nettype wire

FILE: hdl/length_prefixed_packet_deframer_unit.sv
// A byte, or a fetch on an empty ring, is accepted in idle and its result pushed from the
// receive or head state; other fetches read the head byte first, then load a status from
// the size state, or packet bytes from the emit state at one per cycle while the output
// register has room. No new item is taken until in_stall drops: it stays high until the
// final result enters the output register, and a stalled output register holds it high.
// Reset (arst_n): clear pointers, fill, framing, sequencer and output valid; keep ring RAM.
`default_nettype none

module length_prefixed_packet_deframer_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       cmd,
	input  wire logic [ldf_pkg::BYTE_W-1:0] rx_byte,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic      [2:0]                 status,
	output logic      [ldf_pkg::BYTE_W-1:0] data_byte,
	output logic                            last
);

	ldf_pkg::res_t                 push_res, res_q;
	ldf_pkg::ram_req_t             ram_req;
	logic [ldf_pkg::BYTE_W-1:0]    ram_rdata;
	logic                          out_valid_q;
	logic                          room;
	logic                          push;
	logic                          busy;

	// The output register frees up in the cycle its transfer completes, so the
	// sequencer can hand over a new result every cycle while the sink keeps up.
	assign room = !out_valid_q || !out_stall;

	// Hold off new items while the sequencer works on one.
	assign in_stall = busy;

	ldf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cmd       (cmd),
		.rx_byte   (rx_byte),
		.busy      (busy),
		.room      (room),
		.push      (push),
		.res       (push_res),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	// Receive ring: one write port for arriving bytes, one registered read port
	// for the fetch side.
	ldf_ram #(
		.WIDTH (ldf_pkg::BYTE_W),
		.DEPTH (ldf_pkg::RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// Output register: set on push, drop valid once the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload holds while stalled, since push needs room.
	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= push_res;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = res_q.status;
	assign data_byte = res_q.data_byte;
	assign last      = res_q.last;

endmodule

`default_nettype wire
